### rtl/csdc_pkg.sv
// Package for the calendar serial date converter: field widths, stream word
// layout, status codes, month tables and the divide-by-100 reciprocal.
// No dependencies; every module of the block imports it.
`default_nettype none

package csdc_pkg;

  // Default calendar span.
  localparam int DEF_BASE_YEAR = 1900;
  localparam int DEF_NUM_YEARS = 300;

  // Field widths.
  localparam int YEAR_IN_W  = 16;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int SERIAL_W   = 17;
  localparam int YEAR_OUT_W = 12;
  localparam int STATUS_W   = 3;
  localparam int DOY_W      = 9;

  // Stream word widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Calendar constants.
  localparam int DAYS_PER_YEAR  = 365;
  localparam int DAYS_LEAP_YEAR = 366;
  localparam int NUM_MONTHS     = 12;
  localparam int MONTH_FEB      = 2;
  localparam int FEB29_DOY      = 59;

  // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT, exact for y below 2**14.
  localparam int DIV100_MUL   = 10486;
  localparam int DIV100_MUL_W = 14;
  localparam int DIV100_SHIFT = 20;

  localparam logic [DAY_W-1:0] MONTH_LEN [NUM_MONTHS] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [DOY_W-1:0] MONTH_START [NUM_MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EARLY  = 3'd1,
    ST_LATE   = 3'd2,
    ST_MONTH  = 3'd3,
    ST_DAY    = 3'd4,
    ST_SERIAL = 3'd5
  } csdc_status_e;

  // Request fields as they sit in the input word, year in the lowest bits.
  typedef struct packed {
    logic [SERIAL_W-1:0]  serial;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_IN_W-1:0] year;
  } csdc_req_t;

  // Result fields as they sit in the output word, serial in the lowest bits.
  typedef struct packed {
    csdc_status_e          status;
    logic [DAY_W-1:0]      day;
    logic [MONTH_W-1:0]    month;
    logic [YEAR_OUT_W-1:0] year;
    logic [SERIAL_W-1:0]   serial;
  } csdc_res_t;

endpackage

`default_nettype wire

### rtl/calendar_serial_date_converter.sv
// Top level of the calendar serial date converter: stream ports, sequencer,
// shared start-of-year unit and output register. Uses csdc_pkg.
//
// Usage. One request word enters on the slave stream; s_axis_tuser selects
// the direction (0: year/month/day to day serial, 1: day serial to date).
// Exactly one result word leaves on the master stream for every request,
// carrying the serial, year, month, day and a status code. Serial 0 is
// 1 January of BASE_YEAR and NUM_YEARS whole years are covered. On any
// error every field but the status is zero, as are the fields that do not
// belong to the requested direction.
//
// Every start-of-year serial comes from one registered unit, which the
// sequencer waits on after each offset. A date-to-serial request looks up
// the starts of its own year and the one after, then checks the day; a
// failed year or month check goes straight to the result. A serial-to-date
// request checks the serial against the end of the span, ending there when
// out of range, runs at most ceil(log2(NUM_YEARS)) binary search probes and
// then looks up the found year and the one after it, then the month. The slave
// side is ready only while the sequencer is idle, so one request is in flight
// at a time; the next is taken in the cycle after the output register takes a result.
//
// Reset clears the sequencer and the output valid flag. When the receiver
// stalls, the finished word waits in the output register and the next
// request is still accepted and worked on; it then waits for the register.
`default_nettype none

module calendar_serial_date_converter #(
  parameter int BASE_YEAR = csdc_pkg::DEF_BASE_YEAR,
  parameter int NUM_YEARS = csdc_pkg::DEF_NUM_YEARS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // year_in [15:0], month_in [19:16], day_in [24:20], serial_in [41:25], zero above
  input  wire logic [csdc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // kind [0]
  input  wire logic                                 s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // serial_out [16:0], year_out [28:17], month_out [32:29], day_out [37:33],
  // status [40:38], zero above
  output logic [csdc_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);
  import csdc_pkg::*;

  localparam int OffW      = $clog2(NUM_YEARS + 1);
  localparam int LastYear  = BASE_YEAR + NUM_YEARS - 1;
  localparam int LeapsBase = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                             + (BASE_YEAR - 1) / 400;
  localparam int TotalDays = DAYS_PER_YEAR * NUM_YEARS + LastYear / 4 - LastYear / 100
                             + LastYear / 400 - LeapsBase;
  localparam int SerW      = $clog2(TotalDays + 1);
  localparam int ReqW      = $bits(csdc_req_t);
  localparam int ResW      = $bits(csdc_res_t);

  csdc_req_t       req;
  csdc_res_t       res;
  logic            res_valid;
  logic            res_ready;
  logic [OffW-1:0] off;
  logic [SerW-1:0] ys;

  logic            m_valid_q;
  csdc_res_t       m_data_q;

  assign req = csdc_req_t'(s_axis_tdata[ReqW-1:0]);

  csdc_ctrl #(
    .BASE_YEAR (BASE_YEAR),
    .NUM_YEARS (NUM_YEARS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_kind_i  (s_axis_tuser),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .off_o       (off),
    .ys_i        (ys)
  );

  csdc_year_start #(
    .BASE_YEAR (BASE_YEAR),
    .NUM_YEARS (NUM_YEARS)
  ) u_year_start (
    .clk_i (clk_i),
    .off_i (off),
    .ys_o  (ys)
  );

  // The output register takes a new word when empty or being drained.
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-ResW){1'b0}}, m_data_q};

  // A failed check leaves every value field at zero.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_data_q.status != ST_OK)) |->
      ((m_data_q.serial == '0) && (m_data_q.year == '0) &&
       (m_data_q.month == '0) && (m_data_q.day == '0)))
    else $error("error result carries non-zero fields");

  // A successful date lookup yields a real month and day.
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_data_q.status == ST_OK) && (m_data_q.month != '0)) |->
      ((m_data_q.month <= MONTH_W'(NUM_MONTHS)) && (m_data_q.day != '0)))
    else $error("month or day out of range");

  // A request is only taken while no result is pending in the sequencer.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !res_valid)
    else $error("input ready while a result is pending");

  // A handed-over result shows up on the output in the next cycle.
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_axis_tvalid)
    else $error("result lost on its way to the output register");

endmodule

`default_nettype wire

### rtl/csdc_year_start.sv
// Shared start-of-year unit: serial of 1 January of year BASE_YEAR + offset,
// registered: it shows in the cycle after the offset. Uses csdc_pkg.
`default_nettype none

module csdc_year_start #(
  parameter int BASE_YEAR = csdc_pkg::DEF_BASE_YEAR,
  parameter int NUM_YEARS = csdc_pkg::DEF_NUM_YEARS
) (
  input  wire logic                                  clk_i,
  input  wire logic [$clog2(NUM_YEARS+1)-1:0]        off_i,
  output logic [$clog2(
    365*NUM_YEARS + (BASE_YEAR+NUM_YEARS-1)/4 - (BASE_YEAR+NUM_YEARS-1)/100
    + (BASE_YEAR+NUM_YEARS-1)/400 - (BASE_YEAR-1)/4 + (BASE_YEAR-1)/100
    - (BASE_YEAR-1)/400 + 1)-1:0]                     ys_o
);
  import csdc_pkg::*;

  localparam int LastYear  = BASE_YEAR + NUM_YEARS - 1;
  localparam int LeapsBase = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                             + (BASE_YEAR - 1) / 400;
  localparam int TotalDays = DAYS_PER_YEAR * NUM_YEARS + LastYear / 4 - LastYear / 100
                             + LastYear / 400 - LeapsBase;
  localparam int SerW      = $clog2(TotalDays + 1);
  localparam int YrW       = $clog2(BASE_YEAR + NUM_YEARS + 1);
  localparam int ProdW     = YrW + DIV100_MUL_W;
  localparam int QW        = ProdW - DIV100_SHIFT;
  localparam int AccW      = (SerW > YrW) ? SerW : YrW;

  logic [YrW-1:0]   prev_year;
  logic [ProdW-1:0] prod;
  logic [QW-1:0]    q100;
  logic [AccW-1:0]  acc;
  logic [SerW-1:0]  ys_q;

  // 365 days a year plus leap years up to the previous year, less those before the first year.
  always_comb begin
    prev_year = YrW'(BASE_YEAR - 1) + YrW'(off_i);
    prod      = ProdW'(prev_year) * ProdW'(DIV100_MUL);
    q100      = prod[ProdW-1:DIV100_SHIFT];
    acc       = AccW'(off_i) * AccW'(DAYS_PER_YEAR)
              + AccW'(prev_year >> 2)
              - AccW'(q100)
              + AccW'(q100 >> 2)
              - AccW'(LeapsBase);
  end

  always_ff @(posedge clk_i) begin
    ys_q <= SerW'(acc);
  end

  assign ys_o = ys_q;

endmodule

`default_nettype wire

### rtl/csdc_ctrl.sv
// Sequencer of the converter: range checks, binary search over start-of-year
// serials and month lookup; serials come from the shared unit. Uses csdc_pkg.
`default_nettype none

module csdc_ctrl #(
  parameter int BASE_YEAR = csdc_pkg::DEF_BASE_YEAR,
  parameter int NUM_YEARS = csdc_pkg::DEF_NUM_YEARS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           req_valid_i,
  output logic                                req_ready_o,
  input  wire logic                           req_kind_i,
  input  wire csdc_pkg::csdc_req_t            req_i,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output csdc_pkg::csdc_res_t                 res_o,
  output logic [$clog2(NUM_YEARS+1)-1:0]      off_o,
  input  wire logic [$clog2(
    365*NUM_YEARS + (BASE_YEAR+NUM_YEARS-1)/4 - (BASE_YEAR+NUM_YEARS-1)/100
    + (BASE_YEAR+NUM_YEARS-1)/400 - (BASE_YEAR-1)/4 + (BASE_YEAR-1)/100
    - (BASE_YEAR-1)/400 + 1)-1:0]              ys_i
);
  import csdc_pkg::*;

  localparam int OffW      = $clog2(NUM_YEARS + 1);
  localparam int LastYear  = BASE_YEAR + NUM_YEARS - 1;
  localparam int LeapsBase = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                             + (BASE_YEAR - 1) / 400;
  localparam int TotalDays = DAYS_PER_YEAR * NUM_YEARS + LastYear / 4 - LastYear / 100
                             + LastYear / 400 - LeapsBase;
  localparam int SerW      = $clog2(TotalDays + 1);
  localparam int CmpW      = (SerW > SERIAL_W) ? SerW : SERIAL_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHECK  = 10'b0000000010,
    S_D_NEXT = 10'b0000000100,
    S_D_CUR  = 10'b0000001000,
    S_RANGE  = 10'b0000010000,
    S_SEARCH = 10'b0000100000,
    S_NEXT   = 10'b0001000000,
    S_CUR    = 10'b0010000000,
    S_MONTH  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  state_e           state_q, state_d;
  logic             wait_q, wait_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [OffW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [SerW-1:0]  next_q, next_d;
  logic [DOY_W-1:0] doy_q, doy_d;
  logic             leap_q, leap_d;
  logic             kind_q, kind_d;
  csdc_req_t        req_q, req_d;
  csdc_res_t        res_q, res_d;

  logic [OffW-1:0]    lo_n, hi_n, mid_n, year_off;
  logic [MONTH_W-1:0] mon_idx;
  logic               leap_now;
  logic [DAY_W-1:0]   dmax;
  logic [DOY_W-1:0]   doy_adj;
  logic [MONTH_W-1:0] mon_k;

  // Next search bounds: the pending probe sits in off_q.
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (state_q == S_SEARCH) begin
      if (CmpW'(ys_i) <= CmpW'(req_q.serial)) begin
        lo_n = off_q;
      end else begin
        hi_n = off_q - OffW'(1);
      end
    end
    mid_n = OffW'(((OffW+1)'(lo_n) + (OffW+1)'(hi_n) + (OffW+1)'(1)) >> 1);
  end

  // Date-to-serial helpers.
  always_comb begin
    year_off = OffW'(req_q.year - YEAR_IN_W'(BASE_YEAR));
    mon_idx  = req_q.month - MONTH_W'(1);
    leap_now = ((next_q - ys_i) == SerW'(DAYS_LEAP_YEAR));
    dmax     = MONTH_LEN[mon_idx]
             + DAY_W'((req_q.month == MONTH_W'(MONTH_FEB)) && leap_now);
  end

  // Month lookup: last month whose start is not past the day of year.
  always_comb begin
    doy_adj = doy_q - DOY_W'(leap_q && (doy_q > DOY_W'(FEB29_DOY)));
    mon_k   = '0;
    for (int k = 1; k < NUM_MONTHS; k++) begin
      if (doy_adj >= MONTH_START[k]) begin
        mon_k = MONTH_W'(k);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    wait_d  = 1'b0;
    off_d   = off_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    next_d  = next_q;
    doy_d   = doy_q;
    leap_d  = leap_q;
    kind_d  = kind_q;
    req_d   = req_q;
    res_d   = res_q;
    if (!wait_q) begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_d   = req_i;
            kind_d  = req_kind_i;
            res_d   = csdc_res_t'('0);
            state_d = S_CHECK;
          end
        end
        S_CHECK: begin
          if (!kind_q) begin
            if (req_q.year < YEAR_IN_W'(BASE_YEAR)) begin
              res_d.status = ST_EARLY;
              state_d      = S_DONE;
            end else if (req_q.year >= YEAR_IN_W'(BASE_YEAR + NUM_YEARS)) begin
              res_d.status = ST_LATE;
              state_d      = S_DONE;
            end else if ((req_q.month == '0) ||
                         (req_q.month > MONTH_W'(NUM_MONTHS))) begin
              res_d.status = ST_MONTH;
              state_d      = S_DONE;
            end else begin
              off_d   = year_off + OffW'(1);
              wait_d  = 1'b1;
              state_d = S_D_NEXT;
            end
          end else begin
            lo_d    = '0;
            hi_d    = OffW'(NUM_YEARS - 1);
            off_d   = OffW'(NUM_YEARS);
            wait_d  = 1'b1;
            state_d = S_RANGE;
          end
        end
        S_D_NEXT: begin
          next_d  = ys_i;
          off_d   = year_off;
          wait_d  = 1'b1;
          state_d = S_D_CUR;
        end
        S_D_CUR: begin
          if ((req_q.day == '0) || (req_q.day > dmax)) begin
            res_d.status = ST_DAY;
          end else begin
            res_d.serial = SERIAL_W'(ys_i) + SERIAL_W'(MONTH_START[mon_idx])
                         + SERIAL_W'(leap_now && (req_q.month > MONTH_W'(MONTH_FEB)))
                         + SERIAL_W'(req_q.day) - SERIAL_W'(1);
          end
          state_d = S_DONE;
        end
        S_RANGE, S_SEARCH: begin
          if ((state_q == S_RANGE) && (CmpW'(req_q.serial) >= CmpW'(ys_i))) begin
            res_d.status = ST_SERIAL;
            state_d      = S_DONE;
          end else begin
            lo_d   = lo_n;
            hi_d   = hi_n;
            wait_d = 1'b1;
            if (lo_n < hi_n) begin
              off_d   = mid_n;
              state_d = S_SEARCH;
            end else begin
              off_d   = lo_n + OffW'(1);
              state_d = S_NEXT;
            end
          end
        end
        S_NEXT: begin
          next_d  = ys_i;
          off_d   = lo_q;
          wait_d  = 1'b1;
          state_d = S_CUR;
        end
        S_CUR: begin
          doy_d   = DOY_W'(CmpW'(req_q.serial) - CmpW'(ys_i));
          leap_d  = leap_now;
          state_d = S_MONTH;
        end
        S_MONTH: begin
          res_d.year = YEAR_OUT_W'(BASE_YEAR) + YEAR_OUT_W'(lo_q);
          if (leap_q && (doy_q == DOY_W'(FEB29_DOY))) begin
            res_d.month = MONTH_W'(MONTH_FEB);
            res_d.day   = DAY_W'(29);
          end else begin
            res_d.month = mon_k + MONTH_W'(1);
            res_d.day   = DAY_W'(doy_adj - MONTH_START[mon_k] + DOY_W'(1));
          end
          state_d = S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_d = S_IDLE;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    next_q <= next_d;
    doy_q  <= doy_d;
    leap_q <= leap_d;
    kind_q <= kind_d;
    req_q  <= req_d;
    res_q  <= res_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE) && !wait_q;
  assign res_o       = res_q;
  assign off_o       = off_q;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for calendar_serial_date_converter: directed and random
// conversion requests in both directions, checked against an in-bench calendar model.
// Depends on csdc_pkg and the converter RTL only.

module testbench;
  import csdc_pkg::*;

  localparam int BASE_YEAR    = DEF_BASE_YEAR;
  localparam int NUM_YEARS    = DEF_NUM_YEARS;
  localparam int RANDOM_WORDS = 1800;
  localparam int PHASE_WORDS  = RANDOM_WORDS / 4;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int SETTLE_CYCLES = 60;

  localparam logic KIND_TO_SERIAL = 1'b0;
  localparam logic KIND_TO_DATE   = 1'b1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Results still owed by the block, oldest first.
  csdc_res_t awaited_results [$];
  int unsigned fault_count = 0;
  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  calendar_serial_date_converter #(
    .BASE_YEAR(BASE_YEAR),
    .NUM_YEARS(NUM_YEARS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Calendar model
  // ---------------------------------------------------------------------------

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Leap years from year 1 up to and including year y.
  function automatic int unsigned leaps_upto(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Day serial of 1 January of the year that lies off years after the first one.
  function automatic int unsigned jan1_serial(int unsigned off);
    return 365 * off + leaps_upto(BASE_YEAR + off - 1) - leaps_upto(BASE_YEAR - 1);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    return MONTH_LEN[m-1] + ((m == MONTH_FEB && is_leap(y)) ? 1 : 0);
  endfunction

  // Result word that the block owes for one request.
  function automatic csdc_res_t expected_conversion(logic kind, csdc_req_t req);
    csdc_res_t   res;
    int unsigned y, m, d, s, off, doy, k;
    res = '0;
    res.status = ST_OK;
    y = req.year;
    m = req.month;
    d = req.day;
    s = req.serial;
    if (kind == KIND_TO_SERIAL) begin
      // The year is checked before the month, the month before the day.
      if (y < BASE_YEAR) begin
        res.status = ST_EARLY;
      end else if (y >= BASE_YEAR + NUM_YEARS) begin
        res.status = ST_LATE;
      end else if (m < 1 || m > NUM_MONTHS) begin
        res.status = ST_MONTH;
      end else if (d < 1 || d > month_days(y, m)) begin
        res.status = ST_DAY;
      end else begin
        res.serial = SERIAL_W'(jan1_serial(y - BASE_YEAR) + MONTH_START[m-1]
                     + ((m > MONTH_FEB && is_leap(y)) ? 1 : 0) + d - 1);
      end
    end else begin
      if (s >= jan1_serial(NUM_YEARS)) begin
        res.status = ST_SERIAL;
      end else begin
        off = 0;
        while (off + 1 < NUM_YEARS && jan1_serial(off + 1) <= s) off++;
        y = BASE_YEAR + off;
        doy = s - jan1_serial(off);
        if (is_leap(y) && doy == FEB29_DOY) begin
          res.month = MONTH_W'(MONTH_FEB);
          res.day   = DAY_W'(29);
        end else begin
          // Past 29 February a leap year runs one day ahead of the table.
          if (is_leap(y) && doy > FEB29_DOY) doy--;
          k = NUM_MONTHS - 1;
          while (k > 0 && MONTH_START[k] > doy) k--;
          res.month = MONTH_W'(k + 1);
          res.day   = DAY_W'(doy - MONTH_START[k] + 1);
        end
        res.year = YEAR_OUT_W'(y);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Sends one request word and records the result it is owed once accepted.
  // Valid is left high on return so that back-to-back words need no extra
  // assignment; the next call lowers it only when it idles first.
  task automatic send_word(logic kind, csdc_req_t req);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(req);
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    awaited_results.push_back(expected_conversion(kind, req));
  endtask

  // Fields of the other direction are filled with noise; the block must ignore them.
  task automatic send_date(int unsigned y, int unsigned m, int unsigned d);
    csdc_req_t req;
    req.serial = SERIAL_W'($urandom);
    req.year   = YEAR_IN_W'(y);
    req.month  = MONTH_W'(m);
    req.day    = DAY_W'(d);
    send_word(KIND_TO_SERIAL, req);
  endtask

  task automatic send_serial(int unsigned s);
    csdc_req_t req;
    req.year   = YEAR_IN_W'($urandom);
    req.month  = MONTH_W'($urandom);
    req.day    = DAY_W'($urandom);
    req.serial = SERIAL_W'(s);
    send_word(KIND_TO_DATE, req);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic note_fault(string what, int unsigned want, int unsigned got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic check_word(logic [OUT_TDATA_W-1:0] word);
    csdc_res_t got, want;
    got = word[$bits(csdc_res_t)-1:0];
    if (awaited_results.size() == 0) begin
      note_fault("result word with none outstanding", 0, word[31:0]);
    end else begin
      want = awaited_results.pop_front();
      if (got.serial !== want.serial) note_fault("serial_out", want.serial, got.serial);
      if (got.year !== want.year)     note_fault("year_out", want.year, got.year);
      if (got.month !== want.month)   note_fault("month_out", want.month, got.month);
      if (got.day !== want.day)       note_fault("day_out", want.day, got.day);
      if (got.status !== want.status) note_fault("status", want.status, got.status);
    end
  endtask

  // Outputs are sampled at the rising edge, before the block's registers move.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Range limits, check order, bad months, day zero, month ends and leap rules.
  task automatic test_date_checks();
    send_date(BASE_YEAR, 1, 1);
    send_date(BASE_YEAR + NUM_YEARS - 1, 12, 31);
    send_date(BASE_YEAR - 1, 12, 31);
    send_date(0, 0, 0);
    send_date(BASE_YEAR + NUM_YEARS, 1, 1);
    send_date(65535, 15, 31);
    send_date(2000, 0, 1);
    send_date(2000, 13, 1);
    send_date(2000, 15, 31);
    send_date(2000, 2, 29);
    send_date(1900, 2, 29);
    send_date(2001, 2, 29);
    send_date(2000, 1, 0);
    send_date(2000, 4, 31);
    send_date(2000, 12, 31);
  endtask

  // Span limits, the top of the field, year ends and the leap day itself.
  task automatic test_serial_checks();
    send_serial(0);
    send_serial(58);
    send_serial(59);
    send_serial(365);
    // 29 February and 31 December of 2000.
    send_serial(jan1_serial(2000 - BASE_YEAR) + FEB29_DOY);
    send_serial(jan1_serial(2000 - BASE_YEAR + 1) - 1);
    send_serial(jan1_serial(NUM_YEARS) - 1);
    send_serial(jan1_serial(NUM_YEARS));
    send_serial((1 << SERIAL_W) - 1);
  endtask

  // Mostly well-formed requests with random content, plus limit cases and noise,
  // run through four idling patterns in turn.
  task automatic test_random_mix();
    int unsigned pick, y, m, len;
    logic [63:0] noise;
    csdc_req_t   req;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      case (i / PHASE_WORDS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        y = BASE_YEAR + $urandom_range(0, NUM_YEARS - 1);
        m = $urandom_range(1, NUM_MONTHS);
        send_date(y, m, $urandom_range(1, month_days(y, m)));
      end else if (pick < 52) begin
        // Years at and beyond each end of the span, any month, days at and just past both month limits.
        case ($urandom_range(0, 3))
          0: y = BASE_YEAR - 1;
          1: y = BASE_YEAR;
          2: y = BASE_YEAR + NUM_YEARS - 1;
          default: y = BASE_YEAR + NUM_YEARS;
        endcase
        m = $urandom_range(0, 15);
        if (m >= 1 && m <= NUM_MONTHS) begin
          len = month_days(y, m);
          case ($urandom_range(0, 3))
            0: send_date(y, m, 0);
            1: send_date(y, m, 1);
            2: send_date(y, m, len);
            default: send_date(y, m, len + 1);
          endcase
        end else begin
          send_date(y, m, $urandom_range(0, 31));
        end
      end else if (pick < 62) begin
        noise = {$urandom, $urandom};
        req = noise[$bits(csdc_req_t)-1:0];
        send_word(KIND_TO_SERIAL, req);
      end else if (pick < 92) begin
        send_serial($urandom_range(0, jan1_serial(NUM_YEARS) - 1));
      end else begin
        noise = {$urandom, $urandom};
        req = noise[$bits(csdc_req_t)-1:0];
        send_word(KIND_TO_DATE, req);
      end
    end
  endtask

  // Lets the last results come out, then gives the block time to show any stray word.
  task automatic finish_traffic();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0)
      note_fault("results never delivered", 0, awaited_results.size());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_date_checks();
    test_serial_checks();
    test_random_mix();
    finish_traffic();
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legitimate run.
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
